/* design/bfrt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfrt_pkg: shared types and constants of the best-fit run table
// Key layout, status and command codes, and the control bundle that the
// top level broadcasts to every cell of the sorted chain.
// ----------------------------------------------------------------------------
package bfrt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int FIELD_W           = 16;
    localparam int KEY_W             = 4 * FIELD_W;
    localparam int STATUS_W          = 2;

    // Command codes.
    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd3;

    typedef logic [KEY_W-1:0] t_key;

    // Broadcast to all cells. compare loads the per-cell flags; commit
    // applies an insert (put) or a removal (get) using those flags.
    typedef struct packed {
        logic compare;
        logic is_get;
        logic commit;
        t_key key;
    } t_cell_ctrl;

endpackage

/* design/bfrt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfrt_req_if / bfrt_rsp_if: request and response channels
// Valid/ready channels carrying one command or one result per transaction.
// ----------------------------------------------------------------------------
interface bfrt_req_if;
    import bfrt_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [FIELD_W-1:0] largest_block;
    logic [FIELD_W-1:0] free_units;
    logic [FIELD_W-1:0] zone_number;
    logic [FIELD_W-1:0] chunk_number;
    logic [FIELD_W-1:0] request_units;

    modport source (
        output valid, command, largest_block, free_units, zone_number,
               chunk_number, request_units,
        input  ready
    );
    modport sink (
        input  valid, command, largest_block, free_units, zone_number,
               chunk_number, request_units,
        output ready
    );
endinterface

interface bfrt_rsp_if;
    import bfrt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  found_chunk;
    logic [FIELD_W-1:0]  found_zone;
    logic [FIELD_W-1:0]  found_largest;
    logic [FIELD_W-1:0]  found_free;

    modport source (
        output valid, status, found_chunk, found_zone, found_largest, found_free,
        input  ready
    );
    modport sink (
        input  valid, status, found_chunk, found_zone, found_largest, found_free,
        output ready
    );
endinterface

/* design/best_fit_run_table_core.sv */
`timescale 1ns / 1ps
// A result is registered in the commit step that follows its request transaction.
// A new request is taken only after the current one commits (compare, then commit).
// A result waiting at the output holds the commit cycle until it is taken.
// Reset clears every valid bit of the chain at once; no sweep is needed.
// ----------------------------------------------------------------------------
// best_fit_run_table_core: sorted run table with best-fit removal
// A chain of cells keeps the stored descriptors in ascending key order,
// packed toward cell 0. A put shifts larger entries right and drops the new
// key into the gap; a get takes the first entry at or above the bound and
// shifts the entries behind it left.
// ----------------------------------------------------------------------------
module best_fit_run_table_core #(
    parameter int TABLE_ENTRIES = bfrt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfrt_req_if.sink    i_req,
    bfrt_rsp_if.source  o_rsp
);
    import bfrt_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state              r_state;
    logic                r_is_get;
    t_key                r_key;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    t_key                r_found;

    // Chain wiring: one entry per cell.
    logic [TABLE_ENTRIES-1:0] w_valid;
    logic [TABLE_ENTRIES-1:0] w_flag;
    logic [TABLE_ENTRIES-1:0] w_eq;
    logic [TABLE_ENTRIES-1:0] w_hit;
    t_key                     w_key [TABLE_ENTRIES];

    t_cell_ctrl w_ctrl;
    logic       w_accept;
    logic       w_slot_free;
    logic       w_step;
    logic       w_any_eq;
    logic       w_any_flag;
    logic       w_full;
    logic       w_do_put;
    logic       w_do_get;
    t_key       w_in_key;
    t_key       w_found;

    // The request is accepted only when the chain is idle; the compare
    // flags are loaded in the same cycle from the live request fields.
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // A get compares against the bound with its low 48 bits zero, which
    // selects every key whose largest-block field reaches the request.
    assign w_in_key = (i_req.command == CMD_GET)
                    ? {i_req.request_units, {(KEY_W - FIELD_W){1'b0}}}
                    : {i_req.largest_block, i_req.free_units,
                       i_req.zone_number, i_req.chunk_number};

    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign w_step      = (r_state == S_EXEC) && w_slot_free;

    assign w_any_eq   = |w_eq;
    assign w_any_flag = |w_flag;
    assign w_full     = w_valid[TABLE_ENTRIES-1];
    assign w_do_put   = !r_is_get && !w_any_eq && !w_full;
    assign w_do_get   = r_is_get && w_any_flag;

    always_comb begin
        w_ctrl.compare = w_accept;
        w_ctrl.is_get  = w_accept ? (i_req.command == CMD_GET) : r_is_get;
        w_ctrl.commit  = w_step && (w_do_put || w_do_get);
        w_ctrl.key     = w_accept ? w_in_key : r_key;
    end

    // The chain of cells. Cell 0 sees an empty, unflagged left neighbor;
    // the last cell sees an empty right neighbor.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        logic lf;
        logic lv;
        t_key lk;
        logic rv;
        t_key rk;

        if (g == 0) begin : g_first
            assign lf = 1'b0;
            assign lv = 1'b0;
            assign lk = '0;
        end else begin : g_mid_l
            assign lf = w_flag[g-1];
            assign lv = w_valid[g-1];
            assign lk = w_key[g-1];
        end

        if (g == TABLE_ENTRIES - 1) begin : g_last
            assign rv = 1'b0;
            assign rk = '0;
        end else begin : g_mid_r
            assign rv = w_valid[g+1];
            assign rk = w_key[g+1];
        end

        // Flags are monotone along the sorted chain, so the first raised
        // flag marks the best-fit entry of a get.
        assign w_hit[g] = w_flag[g] && !lf;

        bfrt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_left_flag   (lf),
            .i_left_valid  (lv),
            .i_left_key    (lk),
            .i_right_valid (rv),
            .i_right_key   (rk),
            .o_valid       (w_valid[g]),
            .o_key         (w_key[g]),
            .o_flag        (w_flag[g]),
            .o_eq          (w_eq[g])
        );
    end

    // One-hot select of the best-fit key; at most one hit bit is set.
    always_comb begin
        w_found = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_found = w_found | (w_key[i] & {KEY_W{w_hit[i]}});
        end
    end

    // Sequencer and output register. A new result may replace the one
    // being taken in the same cycle, so loading has priority over clearing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_step) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_get <= (i_req.command == CMD_GET);
            r_key    <= w_in_key;
        end
        if (w_step) begin
            if (r_is_get) begin
                r_status <= w_any_flag ? ST_OK : ST_NOMEM;
                r_found  <= w_found;
            end else begin
                if (w_any_eq) begin
                    r_status <= ST_DUP;
                end else if (w_full) begin
                    r_status <= ST_FULL;
                end else begin
                    r_status <= ST_OK;
                end
                r_found <= '0;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.found_chunk   = r_found[FIELD_W-1:0];
    assign o_rsp.found_zone    = r_found[2*FIELD_W-1:FIELD_W];
    assign o_rsp.found_free    = r_found[3*FIELD_W-1:2*FIELD_W];
    assign o_rsp.found_largest = r_found[4*FIELD_W-1:3*FIELD_W];

endmodule

/* design/bfrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfrt_cell: one slot of the sorted descriptor chain
// Holds one key and its valid bit, compares against the broadcast key and
// shifts toward either neighbor on an insert or a removal.
// ----------------------------------------------------------------------------
module bfrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfrt_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_left_flag,
    input  logic                i_left_valid,
    input  bfrt_pkg::t_key      i_left_key,
    input  logic                i_right_valid,
    input  bfrt_pkg::t_key      i_right_key,
    output logic                o_valid,
    output bfrt_pkg::t_key      o_key,
    output logic                o_flag,
    output logic                o_eq
);
    import bfrt_pkg::*;

    logic r_valid;
    t_key r_key;
    logic r_flag;
    logic r_eq;

    logic n_flag;
    logic n_eq;

    always_comb begin
        if (i_ctrl.is_get) begin
            // Entry satisfies the request bound.
            n_flag = r_valid && (r_key >= i_ctrl.key);
        end else begin
            // Entry sits at or after the insert position.
            n_flag = !r_valid || (r_key > i_ctrl.key);
        end
        n_eq = r_valid && (r_key == i_ctrl.key);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_flag  <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_ctrl.compare) begin
                r_flag <= n_flag;
                r_eq   <= n_eq;
            end
            if (i_ctrl.commit && r_flag) begin
                if (i_ctrl.is_get) begin
                    r_valid <= i_right_valid;
                end else if (i_left_flag) begin
                    r_valid <= i_left_valid;
                end else begin
                    r_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit && r_flag) begin
            if (i_ctrl.is_get) begin
                r_key <= i_right_key;
            end else if (i_left_flag) begin
                r_key <= i_left_key;
            end else begin
                r_key <= i_ctrl.key;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_flag  = r_flag;
    assign o_eq    = r_eq;

endmodule

/* bench/best_fit_run_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_run_table_checker: prediction and comparison for the run table
// Watches the request and response channels and keeps its own copy of the
// stored descriptors. Each request transaction yields one expected result,
// and each response transaction is compared with the oldest one waiting.
// ----------------------------------------------------------------------------
module best_fit_run_table_checker #(
    parameter int TABLE_ENTRIES = bfrt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bfrt_req_if  i_req,
    bfrt_rsp_if  i_rsp,
    output int   o_mismatch_count,
    output int   o_pending_count
);
    import bfrt_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  chunk;
        logic [FIELD_W-1:0]  zone;
        logic [FIELD_W-1:0]  largest;
        logic [FIELD_W-1:0]  free;
    } t_run_result;

    t_key        stored_runs[$];
    t_run_result expected_results[$];
    int          mismatches = 0;

    // Applies one command to the stored descriptors and returns its result.
    // Slot numbers never show in a result, so the set is kept as a plain list.
    function automatic t_run_result apply_run_command(
        logic               command,
        logic [FIELD_W-1:0] largest,
        logic [FIELD_W-1:0] free,
        logic [FIELD_W-1:0] zone,
        logic [FIELD_W-1:0] chunk,
        logic [FIELD_W-1:0] request
    );
        t_run_result res;
        t_key        key;
        t_key        bound;
        int          best;
        res = '0;
        if (command == CMD_PUT) begin
            key        = {largest, free, zone, chunk};
            res.status = ST_OK;
            foreach (stored_runs[i]) begin
                if (stored_runs[i] == key) begin
                    res.status = ST_DUP;
                end
            end
            if (res.status == ST_OK) begin
                if (stored_runs.size() >= TABLE_ENTRIES) begin
                    res.status = ST_FULL;
                end else begin
                    stored_runs.push_back(key);
                end
            end
        end else begin
            bound = {request, {(KEY_W - FIELD_W){1'b0}}};
            best  = -1;
            foreach (stored_runs[i]) begin
                if (stored_runs[i] >= bound &&
                    (best < 0 || stored_runs[i] < stored_runs[best])) begin
                    best = i;
                end
            end
            if (best < 0) begin
                res.status = ST_NOMEM;
            end else begin
                res.status  = ST_OK;
                res.largest = stored_runs[best][4*FIELD_W-1:3*FIELD_W];
                res.free    = stored_runs[best][3*FIELD_W-1:2*FIELD_W];
                res.zone    = stored_runs[best][2*FIELD_W-1:FIELD_W];
                res.chunk   = stored_runs[best][FIELD_W-1:0];
                stored_runs.delete(best);
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_run_result got;
        t_run_result want;
        logic        bad;
        if (!i_rst_n) begin
            stored_runs.delete();
            expected_results.delete();
        end else begin
            // The response of this edge always belongs to an earlier request.
            if (i_rsp.valid && i_rsp.ready) begin
                got.status  = i_rsp.status;
                got.chunk   = i_rsp.found_chunk;
                got.zone    = i_rsp.found_zone;
                got.largest = i_rsp.found_largest;
                got.free    = i_rsp.found_free;
                if (expected_results.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result", $realtime);
                        $display("  actual   status=%0d chunk=%h zone=%h largest=%h free=%h",
                                 got.status, got.chunk, got.zone, got.largest, got.free);
                    end
                end else begin
                    want = expected_results.pop_front();
                    bad  = (got.status != want.status) || (got.chunk != want.chunk) ||
                           (got.zone != want.zone) || (got.largest != want.largest) ||
                           (got.free != want.free);
                    if (bad) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected status=%0d chunk=%h zone=%h largest=%h free=%h",
                                     want.status, want.chunk, want.zone, want.largest,
                                     want.free);
                            $display("  actual   status=%0d chunk=%h zone=%h largest=%h free=%h",
                                     got.status, got.chunk, got.zone, got.largest, got.free);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_results.push_back(apply_run_command(
                    i_req.command, i_req.largest_block, i_req.free_units,
                    i_req.zone_number, i_req.chunk_number, i_req.request_units));
            end
        end
        o_mismatch_count <= mismatches;
        o_pending_count  <= expected_results.size();
    end

endmodule

/* bench/best_fit_run_table_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_run_table_core_tb: stimulus and verdict for the best-fit run table
// Drives put and get commands into the core with bursty valid and a stalling
// receiver, while a checker beside the core predicts every result. A short
// directed sequence covers the edge cases, then phases of random traffic
// with a randomly chosen mix of puts and gets fill the table to its limit or drain it.
// ----------------------------------------------------------------------------
module best_fit_run_table_core_tb;
    import bfrt_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int PHASE_ITEMS   = 150;
    // No transaction at all for this many cycles means the core is stuck.
    // The slowest legal stretch is a receiver stall or a sender gap, so this leaves a wide margin.
    localparam int IDLE_LIMIT    = 4000;

    typedef enum logic [1:0] {
        RX_STREAM,  // ready every cycle
        RX_TOGGLE,  // ready every other cycle
        RX_RANDOM,  // ready at random, with a probability of 0.7
        RX_BURSTY   // long runs of ready and of stall
    } t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bfrt_req_if run_req ();
    bfrt_rsp_if run_rsp ();

    int mismatch_count;
    int pending_count;

    always #4 i_clk = ~i_clk;

    best_fit_run_table_core #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (run_req),
        .o_rsp   (run_rsp)
    );

    best_fit_run_table_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (run_req),
        .i_rsp            (run_rsp),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    // ------------------------------------------------------------------------
    // Receiver: the ready pattern switches at random between several modes,
    // so that stalls land on every phase of the core's compare and commit
    // sequence, and stretches of full rate occur as well.
    // ------------------------------------------------------------------------
    t_rx_mode rx_mode      = RX_STREAM;
    int       rx_mode_left = 0;
    int       rx_hold_left = 0;

    initial run_rsp.ready = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_rsp.ready <= 1'b0;
            rx_mode_left  <= 0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= t_rx_mode'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(20, 150);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_STREAM: begin
                    run_rsp.ready <= 1'b1;
                end
                RX_TOGGLE: begin
                    run_rsp.ready <= ~run_rsp.ready;
                end
                RX_RANDOM: begin
                    run_rsp.ready <= ($urandom_range(0, 9) < 7);
                end
                default: begin
                    if (rx_hold_left == 0) begin
                        run_rsp.ready <= ~run_rsp.ready;
                        rx_hold_left  <= $urandom_range(1, 12);
                    end else begin
                        rx_hold_left <= rx_hold_left - 1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which neither channel completes a
    // transaction. The verdict block normally ends the run long before.
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((run_req.valid && run_req.ready) || (run_rsp.valid && run_rsp.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Requests go out in bursts of random length; between bursts the
    // valid line drops for a random gap, which is sometimes zero so that long
    // back-to-back stretches also occur.
    // ------------------------------------------------------------------------
    int   burst_left = 0;
    // Keys put recently, reused to provoke duplicate puts and exact-size gets.
    t_key recent_keys[$];

    task automatic send_run_command(
        input logic               command,
        input logic [FIELD_W-1:0] largest,
        input logic [FIELD_W-1:0] free,
        input logic [FIELD_W-1:0] zone,
        input logic [FIELD_W-1:0] chunk,
        input logic [FIELD_W-1:0] request
    );
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                run_req.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        run_req.valid         <= 1'b1;
        run_req.command       <= command;
        run_req.largest_block <= largest;
        run_req.free_units    <= free;
        run_req.zone_number   <= zone;
        run_req.chunk_number  <= chunk;
        run_req.request_units <= request;
        // Ready is read right after the edge, so it is the value that edge saw.
        do @(posedge i_clk); while (!run_req.ready);
        burst_left = burst_left - 1;
        if (command == CMD_PUT) begin
            recent_keys.push_back({largest, free, zone, chunk});
            if (recent_keys.size() > 32) begin
                void'(recent_keys.pop_front());
            end
        end
    endtask

    // The fields a command does not use carry random values throughout.
    task automatic put_run(
        input logic [FIELD_W-1:0] largest,
        input logic [FIELD_W-1:0] free,
        input logic [FIELD_W-1:0] zone,
        input logic [FIELD_W-1:0] chunk
    );
        send_run_command(CMD_PUT, largest, free, zone, chunk, FIELD_W'($urandom));
    endtask

    task automatic get_run(input logic [FIELD_W-1:0] request);
        send_run_command(CMD_GET, FIELD_W'($urandom), FIELD_W'($urandom),
                         FIELD_W'($urandom), FIELD_W'($urandom), request);
    endtask

    // Holds the request channel idle until every result has come back. The
    // first wait skips the edge of the last request, whose expectation is
    // not yet in the pending count right after that edge.
    task automatic drain_results();
        run_req.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // Field values lean toward a few small numbers so that keys often tie on
    // their leading fields, with the extremes and full-range values mixed in.
    function automatic logic [FIELD_W-1:0] pick_field();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return '0;
            1:       return '1;
            2, 3, 4: return FIELD_W'($urandom_range(0, 7));
            5:       return FIELD_W'($urandom_range(16'hFFF8, 16'hFFFF));
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // Requested sizes are often the exact largest block of a recent put, or
    // one off from it, so that the bound falls right on stored entries.
    function automatic logic [FIELD_W-1:0] pick_request();
        logic [FIELD_W-1:0] base;
        int                 sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && recent_keys.size() > 0) begin
            base = recent_keys[$urandom_range(0, recent_keys.size() - 1)][KEY_W-1:KEY_W-FIELD_W];
            case (sel)
                0:       return base + 1'b1;
                1:       return base - 1'b1;
                default: return base;
            endcase
        end
        return pick_field();
    endfunction

    initial begin : stimulus
        int   put_percent;
        t_key old_key;

        run_req.valid         <= 1'b0;
        run_req.command       <= CMD_PUT;
        run_req.largest_block <= '0;
        run_req.free_units    <= '0;
        run_req.zone_number   <= '0;
        run_req.chunk_number  <= '0;
        run_req.request_units <= '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --------------------------------------------------------------------
        // Directed part.
        // --------------------------------------------------------------------
        // A get on the empty table finds nothing.
        get_run(16'h0000);
        // The largest and the smallest possible keys, then a duplicate.
        put_run(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        put_run(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        put_run(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // Entries that tie on the largest block and differ further down, so
        // the order of free units, zone and chunk decides which one is taken.
        put_run(16'h0005, 16'h000A, 16'h0001, 16'h0002);
        put_run(16'h0005, 16'h000A, 16'h0001, 16'h0001);
        put_run(16'h0005, 16'h0009, 16'h0007, 16'h0007);
        put_run(16'h0006, 16'h0000, 16'h0000, 16'h0000);
        // A request for zero units matches anything and takes the zero key.
        get_run(16'h0000);
        get_run(16'h0005);
        get_run(16'h0005);
        get_run(16'h0006);
        get_run(16'h0005);
        // The largest possible request, first hitting and then missing.
        get_run(16'hFFFF);
        get_run(16'hFFFF);
        get_run(16'h0001);
        // Alternating bit patterns in every field.
        put_run(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        put_run(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        get_run(16'h5556);
        get_run(16'h0000);
        get_run(16'h0000);

        // Let the core settle completely before the random traffic.
        drain_results();

        // --------------------------------------------------------------------
        // Random part. Each phase has its own mix of puts and gets: put-heavy
        // phases run the table into its full state, get-heavy phases drain it
        // until gets start to miss. The first phase always fills.
        // --------------------------------------------------------------------
        put_percent = 85;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n > 0 && n % PHASE_ITEMS == 0) begin
                drain_results();
                case ($urandom_range(0, 2))
                    0:       put_percent = 85;
                    1:       put_percent = 50;
                    default: put_percent = 15;
                endcase
            end
            if ($urandom_range(0, 99) < put_percent) begin
                if (recent_keys.size() > 0 && $urandom_range(0, 4) == 0) begin
                    // Reput a recent key: a duplicate if it is still stored.
                    old_key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                    put_run(old_key[4*FIELD_W-1:3*FIELD_W], old_key[3*FIELD_W-1:2*FIELD_W],
                            old_key[2*FIELD_W-1:FIELD_W], old_key[FIELD_W-1:0]);
                end else begin
                    put_run(pick_field(), pick_field(), pick_field(), pick_field());
                end
            end else begin
                get_run(pick_request());
            end
        end

        // --------------------------------------------------------------------
        // End of run: wait for the last results, then keep watching for anything
        // the core might still send on its own before the verdict.
        // --------------------------------------------------------------------
        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
